@@ rtl/pase_pkg.sv @@
// Shared types and codes for the parenthesised add/subtract stack evaluator.
// No dependencies. Imported by pase_cell and paren_add_sub_stack_evaluator.
`default_nettype none

package pase_pkg;

  // Token kinds on the mode field
  typedef enum logic [2:0] {
    MODE_OPEN  = 3'd0,
    MODE_CLOSE = 3'd1,
    MODE_PLUS  = 3'd2,
    MODE_MINUS = 3'd3,
    MODE_VALUE = 3'd4,
    MODE_END   = 3'd5
  } mode_t;

  // Status codes reported with each result
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_OPERATOR = 3'd1,
    ST_MISSING_OPD = 3'd2,
    ST_UNMATCHED   = 3'd3,
    ST_EMPTY_PAREN = 3'd4,
    ST_ILLEGAL_END = 3'd5,
    ST_OVERFLOW    = 3'd6
  } status_t;

  // Kind of a stack entry
  typedef enum logic [1:0] {
    K_OPEN  = 2'd0,
    K_PLUS  = 2'd1,
    K_MINUS = 2'd2,
    K_VALUE = 2'd3
  } kind_t;

  // One stack entry
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } entry_t;

  // Shift command broadcast to every cell of the stack
  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_PUSH = 2'd1,  // every entry moves one deeper, new entry on top
    SH_POP1 = 2'd2,  // entries move up by one, top replaced
    SH_POP3 = 2'd3   // entries move up by three, top replaced
  } shift_t;

endpackage

`default_nettype wire

@@ rtl/paren_add_sub_stack_evaluator.sv @@
// Top level of the parenthesised add/subtract evaluator: token decode,
// saturating add/sub, occupancy count and the row of pase_cell stack cells.
// Depends on pase_pkg and pase_cell.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, mode, operand    | token in
//  out     | out_valid, out_stall, status,        | result out
//          | result, finished                     |
//
// One token per cycle while in_stall is low, result in the cycle after acceptance:
// every token reads only the top four cells and uses one 33-bit add/sub.
// Synchronous active-high rst empties the stack and clears the held error
// and out_valid; cell contents and the output data are not reset.
// in_stall is high only while a result waits in the output register and
// out_stall is high; a new transaction is taken in the cycle the old one leaves.
`default_nettype none

module paren_add_sub_stack_evaluator
  import pase_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         mode,
  input  wire  signed [31:0] operand,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] result,
  output logic               finished
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Control state
  logic [CW-1:0] cnt, cnt_next;
  status_t       held_error, held_error_next;

  // Stack row
  entry_t cells [STACK_DEPTH];
  entry_t inject;
  shift_t shift;

  // Handshake
  logic take;
  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;

  // Top four entries and occupancy tests
  entry_t t0, t1, t2, t3;
  assign t0 = cells[0];
  assign t1 = cells[1];
  assign t2 = cells[2];
  assign t3 = cells[3];

  logic full;
  assign full = (cnt == CW'(STACK_DEPTH));

  // Saturating add/sub: value token folds into t1, close folds inner into t3
  logic                close_fold;
  logic signed [31:0]  lhs, rhs, sat;
  logic                sub;
  logic signed [32:0]  sum;

  always_comb begin
    close_fold = (mode == MODE_CLOSE);
    lhs = close_fold ? t3.value : t1.value;
    rhs = close_fold ? t0.value : operand;
    sub = close_fold ? (t2.kind == K_MINUS) : (t0.kind == K_MINUS);
    sum = sub ? ({lhs[31], lhs} - {rhs[31], rhs}) : ({lhs[31], lhs} + {rhs[31], rhs});
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
  end

  // Token decode
  status_t            st_out;
  logic signed [31:0] res_out;

  always_comb begin
    cnt_next        = cnt;
    held_error_next = held_error;
    shift           = SH_HOLD;
    inject          = t0;
    st_out          = held_error;
    res_out         = '0;

    if (take) begin
      if (mode == MODE_END) begin
        st_out = held_error;
        if (held_error == ST_OK) begin
          if (cnt == CW'(1) && t0.kind == K_VALUE) begin
            res_out = t0.value;
          end else begin
            st_out = ST_ILLEGAL_END;
          end
        end
        cnt_next        = '0;
        held_error_next = ST_OK;
      end else if (held_error == ST_OK) begin
        case (mode)
          MODE_OPEN: begin
            if (full) begin
              held_error_next = ST_OVERFLOW;
            end else begin
              shift       = SH_PUSH;
              inject.kind = K_OPEN;
              inject.value = '0;
              cnt_next    = cnt + CW'(1);
            end
          end
          MODE_PLUS, MODE_MINUS: begin
            if (cnt == '0 || t0.kind != K_VALUE) begin
              held_error_next = ST_MISSING_OPD;
            end else if (full) begin
              held_error_next = ST_OVERFLOW;
            end else begin
              shift        = SH_PUSH;
              inject.kind  = (mode == MODE_PLUS) ? K_PLUS : K_MINUS;
              inject.value = '0;
              cnt_next     = cnt + CW'(1);
            end
          end
          MODE_VALUE: begin
            if (cnt == '0 || t0.kind == K_OPEN) begin
              if (full) begin
                held_error_next = ST_OVERFLOW;
              end else begin
                shift        = SH_PUSH;
                inject.kind  = K_VALUE;
                inject.value = operand;
                cnt_next     = cnt + CW'(1);
              end
            end else if ((t0.kind == K_PLUS || t0.kind == K_MINUS) && cnt >= CW'(2)) begin
              shift        = SH_POP1;
              inject.kind  = K_VALUE;
              inject.value = sat;
              cnt_next     = cnt - CW'(1);
            end else begin
              held_error_next = ST_NO_OPERATOR;
            end
          end
          MODE_CLOSE: begin
            if (cnt == '0) begin
              held_error_next = ST_UNMATCHED;
            end else if (t0.kind == K_OPEN) begin
              held_error_next = ST_EMPTY_PAREN;
            end else if (t0.kind == K_VALUE) begin
              if (cnt < CW'(2) || t1.kind != K_OPEN) begin
                held_error_next = ST_UNMATCHED;
              end else if (cnt == CW'(2) || t2.kind == K_OPEN) begin
                // group closes onto an open mark or the bottom: value replaces mark
                shift        = SH_POP1;
                inject.kind  = K_VALUE;
                inject.value = t0.value;
                cnt_next     = cnt - CW'(1);
              end else if ((t2.kind == K_PLUS || t2.kind == K_MINUS) && cnt >= CW'(4)) begin
                // group value folds into the pending operation below it
                shift        = SH_POP3;
                inject.kind  = K_VALUE;
                inject.value = sat;
                cnt_next     = cnt - CW'(3);
              end else begin
                held_error_next = ST_NO_OPERATOR;
              end
            end else begin
              held_error_next = ST_MISSING_OPD;
            end
          end
          default: begin
          end
        endcase
        st_out = held_error_next;
      end else begin
        st_out = held_error;
      end
    end
  end

  // Cell row: cell 0 loads the injected entry on every move
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t prev_e, next1_e, next3_e;
    if (i == 0) begin : g_top
      assign prev_e  = inject;
      assign next1_e = inject;
      assign next3_e = inject;
    end else begin : g_body
      assign prev_e = cells[i-1];
      if (i + 1 < STACK_DEPTH) begin : g_n1
        assign next1_e = cells[i+1];
      end else begin : g_n1z
        assign next1_e = '0;
      end
      if (i + 3 < STACK_DEPTH) begin : g_n3
        assign next3_e = cells[i+3];
      end else begin : g_n3z
        assign next3_e = '0;
      end
    end
    pase_cell u_cell (
      .clk        (clk),
      .shift      (shift),
      .from_prev  (prev_e),
      .from_next1 (next1_e),
      .from_next3 (next3_e),
      .ent        (cells[i])
    );
  end

  // Count and held error
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      held_error <= ST_OK;
    end else begin
      cnt        <= cnt_next;
      held_error <= held_error_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status   <= st_out;
      result   <= res_out;
      finished <= (mode == MODE_END);
    end
  end

  // Checks
  a_held_freezes: assert property (@(posedge clk) disable iff (rst)
    (held_error != ST_OK && !(take && mode == MODE_END)) |=> $stable(cnt))
    else $error("stack moved while an error was held");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (take && mode == MODE_END) |=>
      (out_valid && finished && cnt == '0 && held_error == ST_OK))
    else $error("end transaction did not clear the stack");

  a_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !(finished && status == ST_OK)) |-> result == '0)
    else $error("nonzero result without a clean end");

endmodule

`default_nettype wire

@@ rtl/pase_cell.sv @@
// One stack cell: holds a single entry and loads from its neighbours.
// Depends on pase_pkg.
`default_nettype none

module pase_cell
  import pase_pkg::*;
(
  input  wire         clk,
  input  wire shift_t shift,
  input  wire entry_t from_prev,   // entry one place nearer the top
  input  wire entry_t from_next1,  // entry one place deeper
  input  wire entry_t from_next3,  // entry three places deeper
  output entry_t      ent
);

  // Payload only, no reset: occupancy is tracked by the count in the top level
  always_ff @(posedge clk) begin
    case (shift)
      SH_PUSH: ent <= from_prev;
      SH_POP1: ent <= from_next1;
      SH_POP3: ent <= from_next3;
      default: ent <= ent;
    endcase
  end

endmodule

`default_nettype wire
